@@ rtl/rls_pkg.sv @@
// shared constants, opcodes, state encoding and cut flags for the rectangle list
package rls_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 64;
  localparam int unsigned DEF_COORD_BITS  = 16;

  localparam int unsigned FIELD_BITS  = 16;
  localparam int unsigned COUNT_BITS  = 7;
  localparam int unsigned INDEX_BITS  = 6;
  localparam int unsigned OPCODE_BITS = 2;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_APPEND   = 2'd0,
    OP_SUBTRACT = 2'd1,
    OP_READ     = 2'd2,
    OP_CLEAR    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic hit;
    logic up;
    logic down;
    logic left;
    logic right;
  } cut_flags_t;

endpackage

@@ rtl/rls_cut.sv @@
// intersection of the subtract rectangle with one table entry
module rls_cut import rls_pkg::*; #(
  parameter int unsigned COORD_BITS = DEF_COORD_BITS
) (
  input  logic [COORD_BITS-1:0] ent_x_i,
  input  logic [COORD_BITS-1:0] ent_y_i,
  input  logic [COORD_BITS-1:0] ent_w_i,
  input  logic [COORD_BITS-1:0] ent_h_i,
  input  logic [COORD_BITS-1:0] sub_x_i,
  input  logic [COORD_BITS-1:0] sub_y_i,
  input  logic [COORD_BITS:0]   sub_r_i,
  input  logic [COORD_BITS:0]   sub_b_i,
  output logic [COORD_BITS-1:0] cx_o,
  output logic [COORD_BITS-1:0] cy_o,
  output logic [COORD_BITS:0]   cr_o,
  output logic [COORD_BITS:0]   cb_o,
  output logic [COORD_BITS:0]   er_o,
  output logic [COORD_BITS:0]   eb_o,
  output cut_flags_t            flags_o
);

  logic [COORD_BITS:0] ex_w;
  logic [COORD_BITS:0] ey_w;
  logic [COORD_BITS:0] sx_w;
  logic [COORD_BITS:0] sy_w;

  assign ex_w = {1'b0, ent_x_i};
  assign ey_w = {1'b0, ent_y_i};
  assign sx_w = {1'b0, sub_x_i};
  assign sy_w = {1'b0, sub_y_i};

  assign er_o = ex_w + {1'b0, ent_w_i};
  assign eb_o = ey_w + {1'b0, ent_h_i};

  assign cx_o = (sub_x_i > ent_x_i) ? sub_x_i : ent_x_i;
  assign cy_o = (sub_y_i > ent_y_i) ? sub_y_i : ent_y_i;
  assign cr_o = (sub_r_i < er_o) ? sub_r_i : er_o;
  assign cb_o = (sub_b_i < eb_o) ? sub_b_i : eb_o;

  // empty entries are never cut
  assign flags_o.hit = (ent_w_i != '0) && (ent_h_i != '0) &&
                       (sub_r_i > ex_w) && (sx_w < er_o) &&
                       (sub_b_i > ey_w) && (sy_w < eb_o);
  assign flags_o.up    = (cy_o != ent_y_i);
  assign flags_o.down  = (cb_o != eb_o);
  assign flags_o.left  = (cx_o != ent_x_i);
  assign flags_o.right = (cr_o != er_o);

endmodule

@@ rtl/rectangle_list_subtract_core.sv @@
// rectangle list with append, read, clear and subtract over a table memory
//
// Usage: one request on the input channel (valid/stall) gives exactly one
// result on the output channel. Opcodes: append a rectangle, subtract a
// rectangle from every entry live when the request starts, read one entry,
// clear the table. Every result carries the live count and the sticky
// overflow flag.
// Append, read and clear go from acceptance straight to the done state, which
// loads the output register. Subtract walks the live entries through the
// single-port-read table memory: an untouched entry is evaluated and the next
// one fetched; a cut entry is evaluated, then each appended piece (up to three)
// is written, then the entry is replaced while the next one is fetched.
// One request is in work at a time; stall is high until the result has moved
// into the output register, so the next request is taken while a result is
// still held there by a stalled receiver.
// Reset clears the count, the overflow flag and the handshake state; table
// contents stay undefined until written and entries beyond the count are
// never read back.
module rectangle_list_subtract_core import rls_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned COORD_BITS  = DEF_COORD_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [OPCODE_BITS-1:0] opcode_i,
  input  logic [FIELD_BITS-1:0]  rect_x_i,
  input  logic [FIELD_BITS-1:0]  rect_y_i,
  input  logic [FIELD_BITS-1:0]  rect_w_i,
  input  logic [FIELD_BITS-1:0]  rect_h_i,
  input  logic [INDEX_BITS-1:0]  entry_index_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [FIELD_BITS-1:0]  out_x_o,
  output logic [FIELD_BITS-1:0]  out_y_o,
  output logic [FIELD_BITS-1:0]  out_w_o,
  output logic [FIELD_BITS-1:0]  out_h_o,
  output logic [COUNT_BITS-1:0]  live_count_o,
  output logic                   overflow_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned DW = 4 * CB;
  localparam logic [CB:0] PLANE_EDGE = {1'b1, {CB{1'b0}}};
  localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

  // handshake and control
  state_e          state_q, state_d;
  op_e             op_q, op_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic [CW-1:0]   i_q, i_d;
  logic [CW-1:0]   n0_q;
  logic [CW-1:0]   nxt_i;
  logic            rd_hit_q, rd_hit_d;
  logic [2:0]      pend_q, pend_d;
  logic            in_acc;
  logic            cnt_full;
  logic            sub_ld;
  logic            cut_ld;
  logic            out_ld;

  // table memory
  logic [DW-1:0]   mem_q [TABLE_DEPTH];
  logic [DW-1:0]   rd_data_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [DW-1:0]   mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;

  // request rectangle, clipped to the plane
  logic [CB-1:0]   in_x, in_y, in_w, in_h;
  logic [CB:0]     sum_r, sum_b, sat_r, sat_b;
  logic [DW-1:0]   app_data;
  logic            zero_area;

  logic [CB-1:0]   sx_q, sy_q;
  logic [CB:0]     sr_q, sb_q;

  // cut results
  logic [CB-1:0]   rd_x, rd_y, rd_w, rd_h;
  logic [CB-1:0]   cut_cx, cut_cy;
  logic [CB:0]     cut_cr, cut_cb, cut_er, cut_eb;
  cut_flags_t      cut_flags;

  logic [CB-1:0]   cx_q, cy_q, ex_q, ey_q, eh_q;
  logic [CB:0]     cr_q, cb_q, er_q, eb_q;
  cut_flags_t      flags_q;

  logic [DW-1:0]   pc_up, pc_down, pc_left, pc_right, pc_repl;

  // output register
  logic            out_valid_q;
  logic [CB-1:0]   out_x_q, out_y_q, out_w_q, out_h_q;
  logic [CW-1:0]   out_cnt_q;
  logic            out_ovf_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cnt_full   = (cnt_q == DEPTH_CNT);
  assign nxt_i      = i_q + CW'(1);

  assign in_x = rect_x_i[CB-1:0];
  assign in_y = rect_y_i[CB-1:0];
  assign in_w = rect_w_i[CB-1:0];
  assign in_h = rect_h_i[CB-1:0];

  assign sum_r = {1'b0, in_x} + {1'b0, in_w};
  assign sum_b = {1'b0, in_y} + {1'b0, in_h};
  assign sat_r = (sum_r > PLANE_EDGE) ? PLANE_EDGE : sum_r;
  assign sat_b = (sum_b > PLANE_EDGE) ? PLANE_EDGE : sum_b;
  assign zero_area = (in_w == '0) || (in_h == '0);

  assign app_data = {in_x, in_y, CB'(sat_r - {1'b0, in_x}), CB'(sat_b - {1'b0, in_y})};

  assign rd_x = rd_data_q[DW-1 -: CB];
  assign rd_y = rd_data_q[3*CB-1 -: CB];
  assign rd_w = rd_data_q[2*CB-1 -: CB];
  assign rd_h = rd_data_q[CB-1:0];

  rls_cut #(
    .COORD_BITS(COORD_BITS)
  ) u_cut (
    .ent_x_i (rd_x),
    .ent_y_i (rd_y),
    .ent_w_i (rd_w),
    .ent_h_i (rd_h),
    .sub_x_i (sx_q),
    .sub_y_i (sy_q),
    .sub_r_i (sr_q),
    .sub_b_i (sb_q),
    .cx_o    (cut_cx),
    .cy_o    (cut_cy),
    .cr_o    (cut_cr),
    .cb_o    (cut_cb),
    .er_o    (cut_er),
    .eb_o    (cut_eb),
    .flags_o (cut_flags)
  );

  // pieces of the entry being cut
  assign pc_up    = {cx_q, ey_q, CB'(cr_q - {1'b0, cx_q}), CB'(cy_q - ey_q)};
  assign pc_down  = {cx_q, cb_q[CB-1:0], CB'(cr_q - {1'b0, cx_q}), CB'(eb_q - cb_q)};
  assign pc_left  = {ex_q, ey_q, CB'(cx_q - ex_q), eh_q};
  assign pc_right = {cr_q[CB-1:0], ey_q, CB'(er_q - cr_q), eh_q};

  always_comb begin
    priority if (flags_q.up) begin
      pc_repl = pc_up;
    end else if (flags_q.down) begin
      pc_repl = pc_down;
    end else if (flags_q.left) begin
      pc_repl = pc_left;
    end else if (flags_q.right) begin
      pc_repl = pc_right;
    end else begin
      pc_repl = '0;  // fully covered entry
    end
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    i_d       = i_q;
    rd_hit_d  = rd_hit_q;
    pend_d    = pend_q;
    sub_ld    = 1'b0;
    cut_ld    = 1'b0;
    out_ld    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cnt_q[AW-1:0];
    mem_wdata = app_data;
    mem_re    = 1'b0;
    mem_raddr = nxt_i[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d    = op_e'(opcode_i);
          state_d = ST_DONE;
          unique case (op_e'(opcode_i))
            OP_APPEND: begin
              if (cnt_full) begin
                ovf_d = 1'b1;
              end else begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + CW'(1);
              end
            end
            OP_SUBTRACT: begin
              sub_ld = 1'b1;
              i_d    = '0;
              if (!zero_area && (cnt_q != '0)) begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                state_d   = ST_EVAL;
              end
            end
            OP_READ: begin
              mem_re    = 1'b1;
              mem_raddr = AW'(entry_index_i);
              rd_hit_d  = (32'(entry_index_i) < 32'(cnt_q));
            end
            OP_CLEAR: begin
              cnt_d = '0;
              ovf_d = 1'b0;
            end
            default: ;
          endcase
        end
      end

      ST_EVAL: begin
        if (cut_flags.hit) begin
          cut_ld  = 1'b1;
          // appended pieces in order: down, left, right
          pend_d  = {cut_flags.right & (cut_flags.up | cut_flags.down | cut_flags.left),
                     cut_flags.left & (cut_flags.up | cut_flags.down),
                     cut_flags.down & cut_flags.up};
          state_d = ST_WRITE;
        end else if (nxt_i < n0_q) begin
          mem_re  = 1'b1;
          i_d     = nxt_i;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_WRITE: begin
        if (pend_q != '0) begin
          priority if (pend_q[0]) begin
            mem_wdata = pc_down;
            pend_d[0] = 1'b0;
          end else if (pend_q[1]) begin
            mem_wdata = pc_left;
            pend_d[1] = 1'b0;
          end else begin
            mem_wdata = pc_right;
            pend_d[2] = 1'b0;
          end
          if (cnt_full) begin
            ovf_d = 1'b1;
          end else begin
            mem_we = 1'b1;
            cnt_d  = cnt_q + CW'(1);
          end
        end else begin
          // replace the entry and fetch the next one in the same cycle
          mem_we    = 1'b1;
          mem_waddr = i_q[AW-1:0];
          mem_wdata = pc_repl;
          if (nxt_i < n0_q) begin
            mem_re  = 1'b1;
            i_d     = nxt_i;
            state_d = ST_EVAL;
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_ld  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_APPEND;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      i_q         <= '0;
      rd_hit_q    <= 1'b0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      i_q      <= i_d;
      rd_hit_q <= rd_hit_d;
      pend_q   <= pend_d;
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sub_ld) begin
      sx_q <= in_x;
      sy_q <= in_y;
      sr_q <= sat_r;
      sb_q <= sat_b;
      n0_q <= cnt_q;
    end
    if (cut_ld) begin
      cx_q    <= cut_cx;
      cy_q    <= cut_cy;
      cr_q    <= cut_cr;
      cb_q    <= cut_cb;
      er_q    <= cut_er;
      eb_q    <= cut_eb;
      ex_q    <= rd_x;
      ey_q    <= rd_y;
      eh_q    <= rd_h;
      flags_q <= cut_flags;
    end
    if (out_ld) begin
      if ((op_q == OP_READ) && rd_hit_q) begin
        out_x_q <= rd_x;
        out_y_q <= rd_y;
        out_w_q <= rd_w;
        out_h_q <= rd_h;
      end else begin
        out_x_q <= '0;
        out_y_q <= '0;
        out_w_q <= '0;
        out_h_q <= '0;
      end
      out_cnt_q <= cnt_q;
      out_ovf_q <= ovf_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_x_o      = FIELD_BITS'(out_x_q);
  assign out_y_o      = FIELD_BITS'(out_y_q);
  assign out_w_o      = FIELD_BITS'(out_w_q);
  assign out_h_o      = FIELD_BITS'(out_h_q);
  assign live_count_o = COUNT_BITS'(out_cnt_q);
  assign overflow_o   = out_ovf_q;

endmodule
